// ----- rtl/core/ifmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types and constants of the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

	localparam logic [5:0]  MAX_FIELD_WIDTH = 6'd62;
	localparam logic [31:0] RECIP10         = 32'hCCCC_CCCD;
	localparam int          DIG_DEPTH       = 16;

	typedef logic [6:0] char_t;

	localparam char_t CH_SPACE = 7'h20;
	localparam char_t CH_ZERO  = 7'h30;
	localparam char_t CH_MINUS = 7'h2d;
	localparam char_t CH_LX    = 7'h78;
	localparam char_t CH_UX    = 7'h58;
	localparam char_t CH_LA    = 7'h61;

	typedef enum logic [2:0] {
		CMD_SDEC = 3'd0,
		CMD_UDEC = 3'd1,
		CMD_OCT  = 3'd2,
		CMD_HEXL = 3'd3,
		CMD_HEXU = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] np;
		char_t      pre0;
		char_t      pre1;
		logic [5:0] width;
		logic       left;
		logic       zfill;
	} fmt_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [3:0] nd;
	} dig_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} emit_stat_t;

endpackage

// ----- rtl/core/ifmt_digit_unit.sv -----
// ----------------------------------------------------------------------------
// ifmt_digit_unit
// Iterative base conversion: one quotient/remainder step per digit, split
// into a product phase and an update phase; reciprocal multiply for decimal,
// shifts for octal and hex. Digits are stored least significant first.
// ----------------------------------------------------------------------------
module ifmt_digit_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         mag,
	input  ifmt_pkg::base_t     base,
	input  logic [3:0]          rd_idx,
	output logic [3:0]          rd_digit,
	output ifmt_pkg::dig_stat_t stat
);
	import ifmt_pkg::*;

	logic        busy_q;
	logic        phase_q;
	logic        done_q;
	logic [3:0]  nd_q;
	logic [31:0] mag_q;
	base_t       base_q;
	logic [63:0] prod_q;
	logic [3:0]  dig_q [DIG_DEPTH];

	logic [31:0] quot;
	logic [31:0] q10;
	logic [3:0]  digit;

	always_comb begin
		quot  = 32'd0;
		q10   = 32'd0;
		digit = 4'd0;
		case (base_q)
			BASE_DEC: begin
				quot  = {3'b000, prod_q[63:35]};
				q10   = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
				digit = mag_q[3:0] - q10[3:0];
			end
			BASE_OCT: begin
				quot  = {3'b000, mag_q[31:3]};
				digit = {1'b0, mag_q[2:0]};
			end
			default: begin
				quot  = {4'b0000, mag_q[31:4]};
				digit = mag_q[3:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			nd_q    <= 4'd0;
		end else begin
			done_q <= !start && busy_q && phase_q && (quot == 32'd0);
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				nd_q    <= 4'd0;
			end else if (busy_q) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					nd_q    <= nd_q + 4'd1;
					if (quot == 32'd0) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= mag;
			base_q <= base;
		end else if (busy_q) begin
			if (!phase_q) begin
				prod_q <= mag_q * RECIP10;
			end else begin
				mag_q       <= quot;
				dig_q[nd_q] <= digit;
			end
		end
	end

	assign rd_digit  = dig_q[rd_idx];
	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.nd   = nd_q;

endmodule

// ----- rtl/core/ifmt_emitter.sv -----
// ----------------------------------------------------------------------------
// ifmt_emitter
// Walks the field one character per transfer: leading pad, prefix,
// zero pad, digits, trailing pad. Owns the output register.
// ----------------------------------------------------------------------------
module ifmt_emitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ifmt_pkg::fmt_t       fmt,
	input  logic [3:0]           nd,
	output logic [3:0]           rd_idx,
	input  logic [3:0]           rd_digit,
	output ifmt_pkg::emit_stat_t stat,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,  // [6:0] out_char, [7] zero
	output logic                 m_tlast   // last
);
	import ifmt_pkg::*;

	logic       busy_q;
	logic [5:0] k_q;
	logic [5:0] b1_q, b2_q, b3_q, b4_q, last_k_q;
	logic [3:0] ptr_q;
	char_t      pre0_q, pre1_q, padc_q;
	logic       tvalid_q, tlast_q;
	char_t      char_q;

	logic [5:0] text_len, total, pad, lead, mid, b1, b2, b3;
	logic       fire, is_dig, is_last;
	char_t      chr, dchr;

	always_comb begin
		text_len = {4'b0000, fmt.np} + {2'b00, nd};
		total    = (fmt.width > text_len) ? fmt.width : text_len;
		pad      = total - text_len;
		lead     = (!fmt.left && !fmt.zfill) ? pad : 6'd0;
		mid      = (!fmt.left && fmt.zfill) ? pad : 6'd0;
		b1       = lead;
		b2       = b1 + {4'b0000, fmt.np};
		b3       = b2 + mid;
	end

	always_comb begin
		dchr   = (rd_digit < 4'd10) ? (CH_ZERO + {3'b000, rd_digit})
		                            : (CH_LA + {3'b000, rd_digit} - 7'd10);
		is_dig = 1'b0;
		if (k_q < b1_q) begin
			chr = padc_q;
		end else if (k_q < b2_q) begin
			chr = (k_q == b1_q) ? pre0_q : pre1_q;
		end else if (k_q < b3_q) begin
			chr = padc_q;
		end else if (k_q < b4_q) begin
			chr    = dchr;
			is_dig = 1'b1;
		end else begin
			chr = padc_q;
		end
	end

	assign fire    = busy_q && (!tvalid_q || m_tready);
	assign is_last = (k_q == last_k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			tvalid_q <= 1'b0;
			k_q      <= 6'd0;
			ptr_q    <= 4'd0;
		end else begin
			if (fire) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= 6'd0;
				ptr_q  <= nd - 4'd1;
			end else if (fire) begin
				k_q <= k_q + 6'd1;
				if (is_dig) begin
					ptr_q <= ptr_q - 4'd1;
				end
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b1_q     <= b1;
			b2_q     <= b2;
			b3_q     <= b3;
			b4_q     <= b3 + {2'b00, nd};
			last_k_q <= total - 6'd1;
			pre0_q   <= fmt.pre0;
			pre1_q   <= fmt.pre1;
			padc_q   <= fmt.zfill ? CH_ZERO : CH_SPACE;
		end
		if (fire) begin
			char_q  <= chr;
			tlast_q <= is_last;
		end
	end

	assign rd_idx    = ptr_q;
	assign stat.busy = busy_q;
	assign stat.done = fire && is_last;
	assign m_tvalid  = tvalid_q;
	assign m_tdata   = {1'b0, char_q};
	assign m_tlast   = tlast_q;

endmodule

// ----- rtl/core/integer_field_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_field_formatter
// Formats one integer (signed/unsigned decimal, octal, hex) as a padded
// ASCII field, one character per output transfer.
//
//   channel  dir  fields
//   s_axis   in   tdata: command, value, long_value, field_width,
//                        left_justify, zero_fill
//   m_axis   out  tdata: out_char; tlast: last
//
// Conversion runs one digit per step of the shared divide-by-base unit
// (reciprocal multiplier for decimal), up to 11 digits.
// Emission then sends one character per cycle while m_tready allows,
// max(width, text) of them. Input is accepted only while idle.
// Reset clears the sequencer and output valid; no clearing pass.
// Low m_tready holds the output register and pauses emission.
// ----------------------------------------------------------------------------
module integer_field_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] command, [34:3] value, [35] long_value, [41:36] field_width,
	// [42] left_justify, [43] zero_fill, [47:44] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] out_char, [7] zero
	output logic        m_tlast   // last
);
	import ifmt_pkg::*;

	state_t     state_q, state_nxt;
	logic       accept, cmd_ok, dig_start;
	logic [2:0] cmd;
	logic [31:0] raw, mag;
	logic       neg;
	base_t      base;
	fmt_t       fmt_in, fmt_q;
	logic [5:0] width_in;
	logic [3:0] rd_idx, rd_digit;
	dig_stat_t  dstat;
	emit_stat_t estat;

	assign cmd    = s_tdata[2:0];
	assign accept = s_tvalid && s_tready;
	assign cmd_ok = (cmd <= CMD_HEXU);

	always_comb begin
		raw      = s_tdata[35] ? s_tdata[34:3]
		         : {{16{(cmd == CMD_SDEC) && s_tdata[18]}}, s_tdata[18:3]};
		neg      = (cmd == CMD_SDEC) && raw[31];
		mag      = neg ? (32'd0 - raw) : raw;
		width_in = (s_tdata[41:36] > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : s_tdata[41:36];
		fmt_in.width = width_in;
		fmt_in.left  = s_tdata[42];
		fmt_in.zfill = s_tdata[43];
		fmt_in.np    = 2'd0;
		fmt_in.pre0  = CH_ZERO;
		fmt_in.pre1  = CH_LX;
		base         = BASE_HEX;
		case (cmd)
			CMD_SDEC: begin
				base        = BASE_DEC;
				fmt_in.np   = neg ? 2'd1 : 2'd0;
				fmt_in.pre0 = CH_MINUS;
			end
			CMD_UDEC: begin
				base = BASE_DEC;
			end
			CMD_OCT: begin
				base      = BASE_OCT;
				fmt_in.np = (mag != 32'd0) ? 2'd1 : 2'd0;
			end
			default: begin
				fmt_in.np   = 2'd2;
				fmt_in.pre1 = (cmd == CMD_HEXU) ? CH_UX : CH_LX;
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && cmd_ok) state_nxt = ST_CONV;
			ST_CONV: if (dstat.done) state_nxt = ST_EMIT;
			ST_EMIT: if (estat.done) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		dig_start = (state_q == ST_IDLE) && accept && cmd_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_start) begin
			fmt_q <= fmt_in;
		end
	end

	ifmt_digit_unit u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dig_start),
		.mag      (mag),
		.base     (base),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.stat     (dstat)
	);

	ifmt_emitter u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstat.done),
		.fmt      (fmt_q),
		.nd       (dstat.nd),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.stat     (estat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_dig_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == ST_CONV))
		else $error("digit unit finished outside conversion");

	a_emit_done_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		estat.done |-> (state_q == ST_EMIT))
		else $error("emitter finished outside emission");

	a_emit_idle_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_CONV) |-> !estat.busy)
		else $error("emitter busy outside emission");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (dstat.nd >= 4'd1 && dstat.nd <= 4'd11))
		else $error("digit count out of range");

	a_conv_starts: assert property (@(posedge clk) disable iff (!arst_n)
		dig_start |=> dstat.busy)
		else $error("conversion did not start");
`endif

endmodule

// ----- test/tb_integer_field_formatter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_field_formatter
// Feeds integer/conversion items into the formatter with bursty input and a
// stalling output, predicts each padded ASCII field, and checks every output
// transfer (character and last mark) in order against the prediction.
// ----------------------------------------------------------------------------
module tb_integer_field_formatter;
	import ifmt_pkg::*;

	typedef struct packed {
		char_t ch;
		logic  last;
	} field_char_t;

	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam int RANDOM_ITEMS = 280;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 120;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	logic [47:0] pending_items[$];
	field_char_t expected_chars[$];
	field_char_t want;

	int errors         = 0;
	int items_accepted = 0;
	int items_ignored  = 0;
	int chars_checked  = 0;
	int holds_done     = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int rx_mode        = 0;
	int rx_mode_left   = 0;
	int rx_tick        = 0;
	int hold_left      = 0;

	integer_field_formatter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic logic [47:0] make_item(input logic [2:0] cmd, input logic [31:0] value,
			input logic lng, input logic [5:0] wid, input logic lj, input logic zf);
		return {4'b0, zf, lj, wid, lng, value, cmd};
	endfunction

	function automatic logic [47:0] random_item();
		logic [2:0]  cmd;
		logic [31:0] value;
		logic [5:0]  wid;
		if ($urandom_range(99) < 5)
			cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
		else
			cmd = 3'($urandom_range(CMD_HEXU, CMD_SDEC));
		case ($urandom_range(7))
			0: value = $urandom_range(9);
			1: value = $urandom_range(65535);
			2: value = 32'hffff_ffff - $urandom_range(20);
			3: value = 32'h8000_0000 ^ $urandom_range(3);
			4: value = 32'h0000_8000 ^ $urandom_range(3);
			5: value = 32'd999_999_999 + $urandom_range(2);
			default: value = $urandom();
		endcase
		if ($urandom_range(99) < 80)
			wid = 6'($urandom_range(16));
		else
			wid = 6'($urandom_range(63, 17));
		return make_item(cmd, value, 1'($urandom_range(1)), wid, 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endfunction

	// Expected characters of one accepted item, appended in output order.
	task automatic predict_field(input logic [47:0] item);
		logic [2:0]  cmd;
		logic [31:0] raw;
		logic [31:0] mag;
		logic [31:0] base;
		logic [31:0] d;
		logic [5:0]  wid;
		logic        lj;
		logic        zf;
		char_t       fill;
		char_t       prefix[$];
		char_t       digits[$];
		char_t       field[$];
		int          pad;
		cmd = item[2:0];
		raw = item[34:3];
		wid = item[41:36];
		lj  = item[42];
		zf  = item[43];
		if (cmd > CMD_HEXU) begin
			items_ignored++;
			return;
		end
		if (wid > MAX_FIELD_WIDTH)
			wid = MAX_FIELD_WIDTH;
		if (!item[35])
			raw = (cmd == CMD_SDEC) ? {{16{raw[15]}}, raw[15:0]} : {16'h0, raw[15:0]};
		mag = raw;
		if (cmd == CMD_SDEC && raw[31]) begin
			mag = -raw;
			prefix.push_back(CH_MINUS);
		end
		case (cmd)
			CMD_OCT: begin
				base = 8;
				if (mag != 0)
					prefix.push_back(CH_ZERO);
			end
			CMD_HEXL, CMD_HEXU: begin
				base = 16;
				prefix.push_back(CH_ZERO);
				prefix.push_back(cmd == CMD_HEXL ? CH_LX : CH_UX);
			end
			default: base = 10;
		endcase
		do begin
			d = mag % base;
			digits.push_front(d < 10 ? char_t'(CH_ZERO + d) : char_t'(CH_LA + d - 10));
			mag = mag / base;
		end while (mag != 0);
		pad = int'(wid) - prefix.size() - digits.size();
		if (pad < 0)
			pad = 0;
		fill = zf ? CH_ZERO : CH_SPACE;
		if (!lj && !zf)
			repeat (pad) field.push_back(fill);
		foreach (prefix[i])
			field.push_back(prefix[i]);
		if (!lj && zf)
			repeat (pad) field.push_back(fill);
		foreach (digits[i])
			field.push_back(digits[i]);
		if (lj)
			repeat (pad) field.push_back(fill);
		foreach (field[i])
			expected_chars.push_back({field[i], 1'(i == field.size() - 1)});
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				items_accepted++;
				predict_field(s_tdata);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || pending_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_items.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(16);
						case ($urandom_range(3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(3);
							2: gap_left = $urandom_range(12);
							default: gap_left = $urandom_range(40);
						endcase
					end
				end
			end
		end
	end

	// Receiver: checks each transfer, stalls per a changing mode, and holds off
	// for a long stretch twice so the input side backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer, actual char %h last %b", $time,
						m_tdata[6:0], m_tlast);
				end else begin
					want = expected_chars.pop_front();
					chars_checked++;
					if (m_tdata[6:0] !== want.ch) begin
						errors++;
						$display("%0t: out_char mismatch, expected %h actual %h", $time,
							want.ch, m_tdata[6:0]);
					end
					if (m_tlast !== want.last) begin
						errors++;
						$display("%0t: last mismatch, expected %b actual %b", $time,
							want.last, m_tlast);
					end
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(3);
				rx_mode_left = $urandom_range(512, 32);
			end else begin
				rx_mode_left--;
			end
			rx_tick++;
			if (hold_left == 0 && holds_done < 2
					&& chars_checked >= (holds_done == 0 ? 150 : 2000)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(1));
					2: m_tready <= ($urandom_range(3) == 0);
					default: m_tready <= (rx_tick % 3 != 0);
				endcase
			end
		end
	end

	initial begin
		// zero, most negative, largest positive, 16-bit sign extension
		pending_items.push_back(make_item(CMD_SDEC, 32'd0, 1'b1, 6'd0, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_SDEC, 32'h8000_0000, 1'b1, 6'd0, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_SDEC, 32'h7fff_ffff, 1'b1, 6'd0, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_SDEC, 32'hffff_8000, 1'b0, 6'd10, 1'b0, 1'b1));
		pending_items.push_back(make_item(CMD_SDEC, 32'hffff_ffff, 1'b1, 6'd8, 1'b1, 1'b1));
		pending_items.push_back(make_item(CMD_SDEC, 32'h0000_ffff, 1'b0, 6'd3, 1'b1, 1'b0));
		pending_items.push_back(make_item(CMD_SDEC, 32'd1000000000, 1'b1, 6'd63, 1'b0, 1'b1));
		pending_items.push_back(make_item(CMD_UDEC, 32'hffff_ffff, 1'b1, 6'd0, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_UDEC, 32'h1234_5678, 1'b0, 6'd20, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_UDEC, 32'd0, 1'b1, 6'd1, 1'b1, 1'b0));
		pending_items.push_back(make_item(CMD_UDEC, 32'd1000000000, 1'b1, 6'd10, 1'b0, 1'b1));
		pending_items.push_back(make_item(CMD_OCT, 32'd0, 1'b1, 6'd5, 1'b0, 1'b1));
		pending_items.push_back(make_item(CMD_OCT, 32'hffff_ffff, 1'b1, 6'd0, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_OCT, 32'o127, 1'b0, 6'd6, 1'b1, 1'b0));
		pending_items.push_back(make_item(CMD_HEXL, 32'd0, 1'b1, 6'd0, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_HEXL, 32'hdead_beef, 1'b1, 6'd12, 1'b0, 1'b1));
		pending_items.push_back(make_item(CMD_HEXL, 32'h1fff_ffff, 1'b1, 6'd11, 1'b1, 1'b0));
		pending_items.push_back(make_item(CMD_HEXU, 32'hffff_ffff, 1'b1, 6'd62, 1'b1, 1'b1));
		pending_items.push_back(make_item(CMD_HEXU, 32'hffff_abcd, 1'b0, 6'd63, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_UNUSED_LO, 32'd1, 1'b1, 6'd4, 1'b0, 1'b0));
		pending_items.push_back(make_item(CMD_UNUSED_LO + 3'd1, 32'hffff_ffff, 1'b0, 6'd63,
			1'b1, 1'b1));
		pending_items.push_back(make_item(CMD_UNUSED_HI, 32'h5555_aaaa, 1'b1, 6'd9, 1'b0, 1'b1));
		repeat (RANDOM_ITEMS) pending_items.push_back(random_item());

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d fields (%0d with unknown commands) and %0d characters,",
			items_accepted, items_ignored, chars_checked);
		$display("with %0d long output hold-offs and %0d errors.", holds_done, errors);
		if (errors == 0 && expected_chars.size() == 0)
			$display("tb_integer_field_formatter: PASS");
		else
			$display("tb_integer_field_formatter: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_integer_field_formatter: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ifmt_pkg.sv
rtl/core/ifmt_digit_unit.sv
rtl/core/ifmt_emitter.sv
rtl/core/integer_field_formatter.sv
test/tb_integer_field_formatter.sv
